// ----- rtl/rzfr_pkg.sv -----
// Shared constants and types for the r-z line fit residual block.
package rzfr_pkg;

    localparam int COORD_BITS      = 18;
    localparam int MAX_HITS        = 4;
    localparam int SLOPE_FRAC_BITS = 16;

    localparam int CNT_BITS   = $clog2(MAX_HITS + 1);
    localparam int RAD_BITS   = 2 * COORD_BITS;
    localparam int SQRT_BITS  = COORD_BITS;
    localparam int SUM_Z_BITS = 21;
    localparam int SUM_R_BITS = 21;
    localparam int SUM_P_BITS = 39;

    localparam int ALU_W          = 64;
    localparam int ALU_CNT_BITS   = $clog2(ALU_W + 1);
    localparam int PROD_LIMIT_LOG = 61;
    localparam logic [ALU_W-1:0] PROD_LIMIT = ALU_W'(1) << PROD_LIMIT_LOG;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic             start;
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [ALU_W-1:0] y;
    } t_alu_rsp;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FEW_HITS,
        ST_DEGENERATE,
        ST_NO_TARGET
    } t_status;

endpackage

// ----- rtl/rz_line_fit_residual.sv -----
// Top level of the r-z line fit residual block: sequencer, accumulators and stream ports.
//
// Each word carries one point. The block forms its radius with a bit-serial integer sqrt,
// accumulates seed hits and keeps the latest target word as the first target; the word with
// tlast closes the track, fits r = slope*z + intercept and returns both target residuals with
// a status. The time a non-closing word takes is set by the 18-step sqrt. The time a closing
// word takes is set by the shared
// multiply/divide unit: one 64-step division for the slope and one per target residual, plus
// multiplies that handle one bit of their second operand per cycle; an error status skips most
// of that work. One word is in work at a time; a finished result waits in the output register
// while the next word is taken.
module rz_line_fit_residual (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // pos_x, pos_y, pos_z, point_valid, zero fill
    input  logic        i_s_tuser,  // is_target
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata   // residual_first, residual_second, status, zero fill
);
    import rzfr_pkg::*;

    localparam int MUL_BITS = COORD_BITS + 1;
    localparam int MP_BITS  = 2 * MUL_BITS;
    localparam int OUT_BITS = 2 * COORD_BITS + 2;
    localparam int OUT_DATA = ((OUT_BITS + 7) / 8) * 8;
    localparam logic [ALU_W-1:0] Q_POS_LIM = (ALU_W'(1) << (COORD_BITS - 1)) - ALU_W'(1);
    localparam logic [ALU_W-1:0] Q_NEG_LIM = ALU_W'(1) << (COORD_BITS - 1);
    localparam logic signed [COORD_BITS-1:0] OUT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] OUT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE, S_X2, S_Y2, S_SQRT_GO, S_SQRT, S_ZR, S_ZZ, S_CLOSE, S_DEN1, S_DEN2,
        S_NUM1, S_NUM2, S_SLOPE, S_RA, S_DZ, S_PRD, S_RDIV, S_OUT
    } t_state;

    t_state r_state;

    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic                         r_valid;
    logic                         r_target;
    logic                         r_last;
    logic [RAD_BITS-1:0]          r_rad;
    logic [SQRT_BITS-1:0]         r_r;

    logic [CNT_BITS-1:0]          r_cnt;
    logic [SUM_Z_BITS-1:0]        r_sum_z;
    logic [SUM_R_BITS-1:0]        r_sum_r;
    logic [SUM_P_BITS-1:0]        r_sum_zr;
    logic [SUM_P_BITS-1:0]        r_sum_zz;
    logic signed [COORD_BITS-1:0] r_ft_z;
    logic [SQRT_BITS-1:0]         r_ft_r;
    logic                         r_ft_ok;

    logic [ALU_W-1:0]             r_t1, r_den, r_mag, r_a;
    logic                         r_neg, r_dz_neg, r_numr_neg, r_which;
    logic signed [COORD_BITS-1:0] r_res0, r_res1;
    t_status                      r_status;
    t_alu_req                     r_req;

    logic                r_m_valid;
    logic [OUT_DATA-1:0] r_m_data;

    t_alu_rsp alu_rsp;
    logic                 sq_start;
    logic                 sq_done;
    logic [SQRT_BITS-1:0] sq_res;

    logic signed [MUL_BITS-1:0] ma, mb;
    logic signed [MP_BITS-1:0]  m_p;

    logic [ALU_W-1:0] n64, sz64, sz_abs, sr64, szr64, szz64;
    logic [ALU_W-1:0] alu_y, diff, diff_abs;
    logic [ALU_W-1:0] tz64, ra, dz, dz_abs, p, numr, numr_abs, half, dvs;
    logic             p_neg;
    logic signed [COORD_BITS-1:0] res_sat, res_div;

    rzfr_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_req),
        .o_rsp   (alu_rsp)
    );

    rzfr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_rad),
        .o_done  (sq_done),
        .o_sqrt  (sq_res)
    );

    assign sq_start   = r_state == S_SQRT_GO;
    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    always_comb begin
        case (r_state)
            S_X2: begin
                ma = MUL_BITS'(r_px);
                mb = MUL_BITS'(r_px);
            end
            S_Y2: begin
                ma = MUL_BITS'(r_py);
                mb = MUL_BITS'(r_py);
            end
            S_ZR: begin
                ma = MUL_BITS'(r_pz);
                mb = signed'({1'b0, r_r});
            end
            default: begin
                ma = MUL_BITS'(r_pz);
                mb = MUL_BITS'(r_pz);
            end
        endcase
    end

    assign m_p = ma * mb;

    assign n64      = {{(ALU_W-CNT_BITS){1'b0}}, r_cnt};
    assign sz64     = {{(ALU_W-SUM_Z_BITS){r_sum_z[SUM_Z_BITS-1]}}, r_sum_z};
    assign sz_abs   = sz64[ALU_W-1] ? -sz64 : sz64;
    assign sr64     = {{(ALU_W-SUM_R_BITS){1'b0}}, r_sum_r};
    assign szr64    = {{(ALU_W-SUM_P_BITS){r_sum_zr[SUM_P_BITS-1]}}, r_sum_zr};
    assign szz64    = {{(ALU_W-SUM_P_BITS){1'b0}}, r_sum_zz};
    assign alu_y    = alu_rsp.y;
    assign diff     = r_t1 - alu_y;
    assign diff_abs = diff[ALU_W-1] ? -diff : diff;
    assign tz64     = r_which ? ALU_W'(r_pz) : ALU_W'(r_ft_z);
    assign ra       = (alu_y - sr64) << SLOPE_FRAC_BITS;
    assign dz       = alu_y - sz64;
    assign dz_abs   = dz[ALU_W-1] ? -dz : dz;
    assign p_neg    = r_neg ^ r_dz_neg;
    assign p        = p_neg ? -alu_y : alu_y;
    assign numr     = r_a - p;
    assign numr_abs = numr[ALU_W-1] ? -numr : numr;
    assign half     = n64 << (SLOPE_FRAC_BITS - 1);
    assign dvs      = n64 << SLOPE_FRAC_BITS;
    assign res_sat  = p_neg ? OUT_MAX : OUT_MIN;

    always_comb begin
        if (!r_numr_neg) begin
            res_div = (alu_y > Q_POS_LIM) ? OUT_MAX : signed'(alu_y[COORD_BITS-1:0]);
        end else begin
            res_div = (alu_y > Q_NEG_LIM) ? OUT_MIN : signed'(-alu_y[COORD_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_req     <= '0;
            r_m_valid <= 1'b0;
            r_cnt     <= '0;
            r_sum_z   <= '0;
            r_sum_r   <= '0;
            r_sum_zr  <= '0;
            r_sum_zz  <= '0;
            r_ft_z    <= '0;
            r_ft_r    <= '0;
            r_ft_ok   <= 1'b0;
            r_which   <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_px     <= i_s_tdata[COORD_BITS-1:0];
                        r_py     <= i_s_tdata[2*COORD_BITS-1:COORD_BITS];
                        r_pz     <= i_s_tdata[3*COORD_BITS-1:2*COORD_BITS];
                        r_valid  <= i_s_tdata[3*COORD_BITS];
                        r_target <= i_s_tuser;
                        r_last   <= i_s_tlast;
                        r_state  <= S_X2;
                    end
                end
                S_X2: begin
                    r_rad   <= m_p[RAD_BITS-1:0];
                    r_state <= S_Y2;
                end
                S_Y2: begin
                    r_rad   <= r_rad + m_p[RAD_BITS-1:0];
                    r_state <= S_SQRT_GO;
                end
                S_SQRT_GO: begin
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_r <= sq_res;
                        if (r_last) begin
                            r_state <= S_CLOSE;
                        end else if (r_target) begin
                            r_ft_z  <= r_pz;
                            r_ft_r  <= sq_res;
                            r_ft_ok <= r_valid;
                            r_state <= S_IDLE;
                        end else if (r_valid && r_cnt < CNT_BITS'(MAX_HITS)) begin
                            r_cnt   <= r_cnt + 1'b1;
                            r_sum_z <= r_sum_z + SUM_Z_BITS'(r_pz);
                            r_sum_r <= r_sum_r + {{(SUM_R_BITS-SQRT_BITS){1'b0}}, sq_res};
                            r_state <= S_ZR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_ZR: begin
                    r_sum_zr <= r_sum_zr + SUM_P_BITS'(m_p);
                    r_state  <= S_ZZ;
                end
                S_ZZ: begin
                    r_sum_zz <= r_sum_zz + {{(SUM_P_BITS-MP_BITS){1'b0}}, m_p};
                    r_state  <= S_IDLE;
                end
                S_CLOSE: begin
                    if (r_cnt < CNT_BITS'(2)) begin
                        r_status <= ST_FEW_HITS;
                        r_res0   <= '0;
                        r_res1   <= '0;
                        r_state  <= S_OUT;
                    end else begin
                        r_req   <= '{start: 1'b1, op: ALU_MUL, a: szz64, b: n64};
                        r_state <= S_DEN1;
                    end
                end
                S_DEN1: begin
                    if (alu_rsp.done) begin
                        r_t1    <= alu_y;
                        r_req   <= '{start: 1'b1, op: ALU_MUL, a: sz_abs, b: sz_abs};
                        r_state <= S_DEN2;
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_DEN2: begin
                    if (alu_rsp.done) begin
                        r_res0 <= '0;
                        r_res1 <= '0;
                        if (diff[ALU_W-1] || diff == '0) begin
                            r_status <= ST_DEGENERATE;
                            r_state  <= S_OUT;
                        end else if (!r_ft_ok || !r_valid) begin
                            r_status <= ST_NO_TARGET;
                            r_state  <= S_OUT;
                        end else begin
                            r_den   <= diff;
                            r_req   <= '{start: 1'b1, op: ALU_MUL, a: szr64, b: n64};
                            r_state <= S_NUM1;
                        end
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_NUM1: begin
                    if (alu_rsp.done) begin
                        r_t1    <= alu_y;
                        r_req   <= '{start: 1'b1, op: ALU_MUL, a: sz64, b: sr64};
                        r_state <= S_NUM2;
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_NUM2: begin
                    if (alu_rsp.done) begin
                        r_neg   <= diff[ALU_W-1];
                        r_req   <= '{start: 1'b1, op: ALU_DIV,
                                     a: diff_abs << SLOPE_FRAC_BITS, b: r_den};
                        r_state <= S_SLOPE;
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_SLOPE: begin
                    if (alu_rsp.done) begin
                        r_mag   <= alu_y;
                        r_which <= 1'b0;
                        r_req   <= '{start: 1'b1, op: ALU_MUL,
                                     a: {{(ALU_W-SQRT_BITS){1'b0}}, r_ft_r}, b: n64};
                        r_state <= S_RA;
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_RA: begin
                    if (alu_rsp.done) begin
                        r_a     <= ra;
                        r_req   <= '{start: 1'b1, op: ALU_MUL, a: tz64, b: n64};
                        r_state <= S_DZ;
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_DZ: begin
                    if (alu_rsp.done) begin
                        r_dz_neg <= dz[ALU_W-1];
                        r_req    <= '{start: 1'b1, op: ALU_MUL, a: r_mag, b: dz_abs};
                        r_state  <= S_PRD;
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_PRD: begin
                    if (alu_rsp.done) begin
                        if (alu_rsp.ovf) begin
                            if (!r_which) begin
                                r_res0  <= res_sat;
                                r_which <= 1'b1;
                                r_req   <= '{start: 1'b1, op: ALU_MUL,
                                             a: {{(ALU_W-SQRT_BITS){1'b0}}, r_r}, b: n64};
                                r_state <= S_RA;
                            end else begin
                                r_res1   <= res_sat;
                                r_status <= ST_OK;
                                r_state  <= S_OUT;
                            end
                        end else begin
                            r_numr_neg <= numr[ALU_W-1];
                            r_req      <= '{start: 1'b1, op: ALU_DIV, a: numr_abs + half, b: dvs};
                            r_state    <= S_RDIV;
                        end
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_RDIV: begin
                    if (alu_rsp.done) begin
                        if (!r_which) begin
                            r_res0  <= res_div;
                            r_which <= 1'b1;
                            r_req   <= '{start: 1'b1, op: ALU_MUL,
                                         a: {{(ALU_W-SQRT_BITS){1'b0}}, r_r}, b: n64};
                            r_state <= S_RA;
                        end else begin
                            r_res1   <= res_div;
                            r_status <= ST_OK;
                            r_state  <= S_OUT;
                        end
                    end else begin
                        r_req.start <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_data  <= {{(OUT_DATA-OUT_BITS){1'b0}}, r_status, r_res1, r_res0};
                        r_cnt     <= '0;
                        r_sum_z   <= '0;
                        r_sum_r   <= '0;
                        r_sum_zr  <= '0;
                        r_sum_zz  <= '0;
                        r_ft_z    <= '0;
                        r_ft_r    <= '0;
                        r_ft_ok   <= 1'b0;
                        r_which   <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/rzfr_sqrt.sv -----
// Bit-serial integer sqrt, one result bit per clock.
module rzfr_sqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rzfr_pkg::RAD_BITS-1:0]  i_rad,
    output logic                           o_done,
    output logic [rzfr_pkg::SQRT_BITS-1:0] o_sqrt
);
    import rzfr_pkg::*;

    localparam int REM_BITS  = SQRT_BITS + 2;
    localparam int STEP_BITS = $clog2(SQRT_BITS + 1);

    logic                 r_busy;
    logic [STEP_BITS-1:0] r_step;
    logic [RAD_BITS-1:0]  r_rad;
    logic [REM_BITS-1:0]  r_rem;
    logic [SQRT_BITS-1:0] r_res;

    logic [REM_BITS-1:0] rem_sh;
    logic [REM_BITS-1:0] trial;
    logic                geq;
    logic                fin;

    assign rem_sh = {r_rem[REM_BITS-3:0], r_rad[RAD_BITS-1 -: 2]};
    assign trial  = {r_res, 2'b01};
    assign geq    = rem_sh >= trial;
    assign fin    = r_step == STEP_BITS'(SQRT_BITS);
    assign o_done = r_busy && fin;
    assign o_sqrt = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_res  <= '0;
        end else if (r_busy) begin
            if (fin) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
                r_rad  <= {r_rad[RAD_BITS-3:0], 2'b00};
                r_rem  <= geq ? rem_sh - trial : rem_sh;
                r_res  <= {r_res[SQRT_BITS-2:0], geq};
            end
        end
    end

endmodule

// ----- rtl/rzfr_alu.sv -----
// Shared iterative unit: shift-add multiply with overflow flag and restoring divide.
module rzfr_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rzfr_pkg::t_alu_req i_req,
    output rzfr_pkg::t_alu_rsp o_rsp
);
    import rzfr_pkg::*;

    logic                    r_busy;
    t_alu_op                 r_op;
    logic [ALU_W-1:0]        r_x;
    logic [ALU_W-1:0]        r_y;
    logic [ALU_W-1:0]        r_acc;
    logic [ALU_CNT_BITS-1:0] r_cnt;
    logic                    r_ovf;

    logic [ALU_W:0]   opa;
    logic [ALU_W:0]   opb;
    logic [ALU_W+1:0] sum;
    logic             geq;
    logic             is_mul;
    logic             fin;

    assign is_mul = r_op == ALU_MUL;
    assign opa    = is_mul ? {1'b0, r_acc} : {r_acc, r_x[ALU_W-1]};
    assign opb    = is_mul ? {1'b0, r_x} : {1'b0, r_y};
    assign sum    = is_mul ? {1'b0, opa} + {1'b0, opb} : {1'b0, opa} - {1'b0, opb};
    assign geq    = !sum[ALU_W+1];
    assign fin    = is_mul ? (r_y == '0) : (r_cnt == '0);

    assign o_rsp.done = r_busy && fin;
    assign o_rsp.ovf  = r_ovf || (r_acc > PROD_LIMIT);
    assign o_rsp.y    = is_mul ? r_acc : r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= ALU_MUL;
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_op   <= i_req.op;
            r_x    <= i_req.a;
            r_y    <= i_req.b;
            r_acc  <= '0;
            r_cnt  <= ALU_CNT_BITS'(ALU_W);
            r_ovf  <= 1'b0;
        end else if (r_busy) begin
            if (fin) begin
                r_busy <= 1'b0;
            end else if (is_mul) begin
                if (r_y[0]) begin
                    r_acc <= sum[ALU_W-1:0];
                end
                if ((r_y[0] && sum[ALU_W:ALU_W-2] != '0)
                        || (r_x[ALU_W-1:ALU_W-2] != '0 && r_y[ALU_W-1:1] != '0)) begin
                    r_ovf <= 1'b1;
                end
                r_x <= {r_x[ALU_W-2:0], 1'b0};
                r_y <= {1'b0, r_y[ALU_W-1:1]};
            end else begin
                r_acc <= geq ? sum[ALU_W-1:0] : opa[ALU_W-1:0];
                r_x   <= {r_x[ALU_W-2:0], geq};
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- test/rz_line_fit_residual_tb.sv -----
// Testbench for the r-z line fit residual block: directed and random tracks checked against a predictor.
`timescale 1ns / 100ps

module rz_line_fit_residual_tb;
    import rzfr_pkg::*;

    typedef struct packed {
        logic        last;
        logic        target;
        logic        valid;
        logic [17:0] z;
        logic [17:0] y;
        logic [17:0] x;
    } t_point;

    typedef struct packed {
        t_status     status;
        logic [17:0] res_second;
        logic [17:0] res_first;
    } t_fit_result;

    localparam longint LIMIT61 = 64'sd1 <<< 61;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [55:0] i_s_tdata = '0;
    logic        i_s_tuser = 1'b0;
    logic        i_s_tlast = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;

    rz_line_fit_residual uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_s_tuser(i_s_tuser), .i_s_tlast(i_s_tlast),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    always #1 i_clk = ~i_clk;

    t_point      pending_points[$];
    t_fit_result expected_fits[$];
    int          send_idle_pct = 30;
    int          recv_idle_pct = 45;
    bit          hold_sender = 0;
    int          mismatches = 0;
    int          stalled_cycles = 0;

    int          hits;
    longint      acc_z, acc_r, acc_zr, acc_zz;
    longint      tgt_z, tgt_r;
    bit          tgt_ok;

    function automatic void add_point(t_point pt);
        pending_points = {pending_points, pt};
    endfunction

    function automatic longint sqrt_floor(longint v);
        longint res, bitv;
        res = 0;
        bitv = 64'sd1 <<< 62;
        while (bitv > v) bitv = bitv >>> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >>> 1) + bitv;
            end else begin
                res = res >>> 1;
            end
            bitv = bitv >>> 2;
        end
        return res;
    endfunction

    function automatic longint clamp18(longint v);
        if (v > 131071) return 131071;
        if (v < -131072) return -131072;
        return v;
    endfunction

    function automatic longint target_residual(longint zt, longint rt,
                                               longint slope_mag, bit slope_neg);
        longint a, dz, dzm, p, numr, d, mag, q;
        bit     p_neg;
        a = (hits * rt - acc_r) * 65536;
        dz = hits * zt - acc_z;
        dzm = dz < 0 ? -dz : dz;
        p_neg = (slope_neg != (dz < 0)) && slope_mag != 0 && dzm != 0;
        if (dzm != 0 && slope_mag > LIMIT61 / dzm)
            return p_neg ? 131071 : -131072;
        p = slope_mag * dzm;
        if (p_neg) p = -p;
        numr = a - p;
        d = longint'(hits) * 65536;
        mag = numr < 0 ? -numr : numr;
        q = (mag + d / 2) / d;
        return clamp18(numr < 0 ? -q : q);
    endfunction

    function automatic void predict_point(t_point pt);
        longint      x, y, z, r, den, num, nm, q, rem, mag;
        bit          neg;
        t_fit_result fit;
        x = longint'(signed'(pt.x));
        y = longint'(signed'(pt.y));
        z = longint'(signed'(pt.z));
        r = sqrt_floor(x * x + y * y);
        if (!pt.last) begin
            if (pt.target) begin
                tgt_z = z;
                tgt_r = r;
                tgt_ok = pt.valid;
            end else if (pt.valid && hits < MAX_HITS) begin
                hits++;
                acc_z += z;
                acc_r += r;
                acc_zr += z * r;
                acc_zz += z * z;
            end
            return;
        end
        fit = '0;
        den = hits * acc_zz - acc_z * acc_z;
        if (hits < 2) fit.status = ST_FEW_HITS;
        else if (den <= 0) fit.status = ST_DEGENERATE;
        else if (!tgt_ok || !pt.valid) fit.status = ST_NO_TARGET;
        else fit.status = ST_OK;
        if (fit.status == ST_OK) begin
            num = hits * acc_zr - acc_z * acc_r;
            neg = num < 0;
            nm = neg ? -num : num;
            q = nm / den;
            rem = nm % den;
            if (q > (LIMIT61 >>> 16)) begin
                mag = LIMIT61;
            end else begin
                mag = q <<< 16;
                for (int i = 15; i >= 0; i--) begin
                    rem = rem <<< 1;
                    if (rem >= den) begin
                        rem -= den;
                        mag |= 64'sd1 <<< i;
                    end
                end
            end
            fit.res_first = 18'(target_residual(tgt_z, tgt_r, mag, neg));
            fit.res_second = 18'(target_residual(z, r, mag, neg));
        end
        expected_fits = {expected_fits, fit};
        hits = 0; acc_z = 0; acc_r = 0; acc_zr = 0; acc_zz = 0;
        tgt_z = 0; tgt_r = 0; tgt_ok = 0;
    endfunction

    function automatic logic [17:0] rand_coord(int span);
        case ($urandom_range(0, 5))
            0: return 18'h1ffff;
            1: return 18'h20000;
            2: return 18'($urandom);
            default: return 18'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    function automatic t_point make_point(bit valid, bit target, bit last, int span);
        t_point pt;
        pt.x = rand_coord(span);
        pt.y = rand_coord(span);
        pt.z = rand_coord(span);
        pt.valid = valid;
        pt.target = target;
        pt.last = last;
        return pt;
    endfunction

    function automatic void queue_track(int seeds, int span);
        for (int i = 0; i < seeds; i++)
            add_point(make_point($urandom_range(0, 9) != 0, 0, 0, span));
        if ($urandom_range(0, 15) != 0)
            add_point(make_point($urandom_range(0, 9) != 0, 1, 0, span));
        if ($urandom_range(0, 7) == 0)
            add_point(make_point(1, $urandom_range(0, 1) != 0, 0, span));
        add_point(make_point($urandom_range(0, 9) != 0,
                             $urandom_range(0, 7) != 0, 1, span));
    endfunction

    function automatic t_point exact_point(int x, int y, int z, bit v, bit t, bit l);
        t_point pt;
        pt.x = 18'(x); pt.y = 18'(y); pt.z = 18'(z);
        pt.valid = v; pt.target = t; pt.last = l;
        return pt;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_points.size() != 0 && !hold_sender
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_point pt;
                    pt = pending_points.pop_front();
                    predict_point(pt);
                    i_s_tvalid <= 1'b1;
                    i_s_tdata <= {1'b0, pt.valid, pt.z, pt.y, pt.x};
                    i_s_tuser <= pt.target;
                    i_s_tlast <= pt.last;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
            i_m_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                stalled_cycles <= 0;
            else
                stalled_cycles <= stalled_cycles + 1;
            if (o_m_tvalid && i_m_tready) begin
                if (expected_fits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word %h", o_m_tdata);
                end else begin
                    t_fit_result exp_fit, got;
                    exp_fit = expected_fits.pop_front();
                    got = t_fit_result'(o_m_tdata[37:0]);
                    if (got !== exp_fit || o_m_tdata[39:38] !== 2'b00) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected r1=%0d r2=%0d st=%0d, got r1=%0d r2=%0d st=%0d",
                                     $signed(exp_fit.res_first), $signed(exp_fit.res_second),
                                     exp_fit.status, $signed(got.res_first),
                                     $signed(got.res_second), got.status);
                    end
                end
            end
            if (stalled_cycles > 20000) begin
                $display("rz_line_fit_residual regression: fail");
                $finish;
            end
        end
    end

    initial begin
        hits = 0; acc_z = 0; acc_r = 0; acc_zr = 0; acc_zz = 0;
        tgt_z = 0; tgt_r = 0; tgt_ok = 0;
        // Directed tracks: extremes, too many seeds, too few seeds, invalid seeds, missing targets,
        // a degenerate fit, a closing seed word and a repeated first target.
        add_point(exact_point(131071, 131071, -131072, 1, 0, 0));
        add_point(exact_point(-131072, -131072, 131071, 1, 0, 0));
        add_point(exact_point(100, 0, 5, 0, 0, 0));
        add_point(exact_point(5000, 300, 0, 1, 0, 0));
        add_point(exact_point(7, 9, 11, 1, 0, 0));
        add_point(exact_point(1, 1, 1, 1, 0, 0));
        add_point(exact_point(-131072, 131071, 0, 1, 1, 0));
        add_point(exact_point(3, 4, 0, 1, 1, 0));
        add_point(exact_point(-131072, 0, 131071, 1, 0, 1));
        add_point(exact_point(10, 10, 10, 1, 0, 0));
        add_point(exact_point(10, 10, 10, 1, 1, 0));
        add_point(exact_point(0, 0, 0, 1, 1, 1));
        add_point(exact_point(10, 0, 7, 1, 0, 0));
        add_point(exact_point(20, 0, 7, 1, 0, 0));
        add_point(exact_point(1, 0, 0, 1, 1, 0));
        add_point(exact_point(1, 0, 0, 1, 1, 1));
        add_point(exact_point(100, 0, 0, 1, 0, 0));
        add_point(exact_point(200, 0, 1, 1, 0, 0));
        add_point(exact_point(1, 0, 0, 0, 1, 1));
        add_point(exact_point(100, 0, 0, 1, 0, 0));
        add_point(exact_point(300, 0, 3, 1, 0, 0));
        add_point(exact_point(50, 50, 9, 1, 1, 0));
        add_point(exact_point(-60, 20, 4, 1, 0, 1));
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_points.size() != 0 || expected_fits.size() != 0)
            @(posedge i_clk);
        hold_sender = 1;
        repeat (400) @(posedge i_clk);
        hold_sender = 0;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = phase == 0 ? 30 : (phase == 1 ? 45 : 0);
            recv_idle_pct = phase == 0 ? 45 : (phase == 1 ? 30 : 0);
            for (int k = 0; k < 68; k++)
                queue_track($urandom_range(0, 6),
                            $urandom_range(0, 3) == 0 ? 131071 : $urandom_range(1, 4000));
            while (pending_points.size() != 0) @(posedge i_clk);
        end
        while (expected_fits.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (mismatches == 0 && expected_fits.size() == 0)
            $display("rz_line_fit_residual regression: pass");
        else
            $display("rz_line_fit_residual regression: fail");
        $finish;
    end
endmodule
